// ===== rtl/core/pds_pkg.sv =====
// types, constants and state codes shared by the polyline distance sampler
// no dependencies
`default_nettype none

package pds_pkg;

    localparam int POINT_DEPTH_DEF = 256;
    localparam int COUNT_CAP       = 256;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam logic [16:0] FRAC_ONE = 17'd65536;

    // segment length is the root of a sum of three 66-bit squares
    localparam int SQRT_STEPS = 34;
    localparam int LEN_W      = SQRT_STEPS;
    localparam int SQRT_RAD_W = 2 * SQRT_STEPS;
    localparam int SQRT_REM_W = SQRT_STEPS + 2;
    localparam int DIV_STEPS  = 17;
    localparam int NUM_W      = 36;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [7:0]          point_index;
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  pos_z;
        logic signed [15:0]  up_x;
        logic signed [15:0]  up_y;
        logic signed [15:0]  up_z;
        logic signed [31:0]  distance;
    } pds_req_t;

    typedef struct packed {
        logic                inside_res;
        logic signed [31:0]  leftover;
        logic [7:0]          segment_index;
        logic [16:0]         segment_fraction;
        logic signed [31:0]  sample_x;
        logic signed [31:0]  sample_y;
        logic signed [31:0]  sample_z;
        logic signed [15:0]  sample_up_x;
        logic signed [15:0]  sample_up_y;
        logic signed [15:0]  sample_up_z;
    } pds_rsp_t;

    typedef struct packed {
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic signed [31:0]  z;
        logic signed [15:0]  ux;
        logic signed [15:0]  uy;
        logic signed [15:0]  uz;
    } pds_point_t;

    localparam int POINT_W = $bits(pds_point_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEG_RD_A,
        ST_SEG_RD_B,
        ST_SEG_DIFF,
        ST_SEG_SQ,
        ST_SEG_SQRT_GO,
        ST_SEG_SQRT,
        ST_SEG_COV,
        ST_SEG_STEP,
        ST_SEG_DIV,
        ST_SMP_RD_A,
        ST_SMP_RD_B,
        ST_SMP_LATCH,
        ST_SMP_LERP,
        ST_DONE
    } pds_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/pds_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module pds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pds_sqrt.sv =====
// iterative integer square root, two radicand bits per cycle
// depends on pds_pkg
`default_nettype none

module pds_sqrt (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [pds_pkg::SQRT_RAD_W-1:0]    radicand,
    output logic      [pds_pkg::LEN_W-1:0]         root,
    output logic                                   done
);
    import pds_pkg::*;

    localparam int CNT_W = $clog2(SQRT_STEPS + 1);

    logic [SQRT_RAD_W-1:0] rad_reg;
    logic [SQRT_REM_W-1:0] rem_reg;
    logic [LEN_W-1:0]      root_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [SQRT_REM_W+1:0] rem_sh;
    logic [SQRT_REM_W+1:0] trial;
    logic [SQRT_REM_W+1:0] diff;
    logic                  ge;

    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[SQRT_RAD_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
        diff   = rem_sh - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(SQRT_STEPS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQRT_RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[SQRT_REM_W-1:0] : rem_sh[SQRT_REM_W-1:0];
            root_reg <= {root_reg[LEN_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pds_div.sv =====
// iterative fraction divider: quotient of num * 65536 / den, one bit per cycle
// needs num < 2 * den; depends on pds_pkg
`default_nettype none

module pds_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [pds_pkg::NUM_W-1:0]    num,
    input  wire logic [pds_pkg::LEN_W-1:0]    den,
    output logic      [16:0]                  quot,
    output logic                              done
);
    import pds_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [NUM_W-1:0] rem_reg;
    logic [LEN_W-1:0] den_reg;
    logic [16:0]      q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [NUM_W-1:0] t;
    logic             ge;

    always_comb
    begin
        // the integer bit needs no shift, the sixteen fraction bits do
        t  = (cnt_reg == CNT_W'(DIV_STEPS)) ? rem_reg : {rem_reg[NUM_W-2:0], 1'b0};
        ge = (t >= {{(NUM_W-LEN_W){1'b0}}, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DIV_STEPS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (t - {{(NUM_W-LEN_W){1'b0}}, den_reg}) : t;
            q_reg   <= {q_reg[15:0], ge};
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pds_walker.sv =====
// cursor sequencer: walks segments read from the point ram, samples at the cursor
// depends on pds_pkg, pds_sqrt, pds_div
`default_nettype none

module pds_walker (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    go,
    input  wire pds_pkg::pds_req_t       req,
    input  wire logic [8:0]              n_eff,
    output logic                         busy,
    output logic [7:0]                   rd_index,
    input  wire pds_pkg::pds_point_t     rd_data,
    output pds_pkg::pds_rsp_t            res,
    output logic                         res_valid,
    input  wire logic                    res_take
);
    import pds_pkg::*;

    pds_state_t        state_reg, state_next;
    logic [7:0]        cur_seg_reg, cur_seg_next;
    logic [16:0]       cur_frac_reg, cur_frac_next;
    logic              inside_reg, inside_next;

    logic signed [31:0] d_reg, d_next;
    logic              fwd_reg, fwd_next;
    logic [8:0]        n_reg, n_next;
    logic [7:0]        pa_reg, pa_next;
    logic [7:0]        pb_reg, pb_next;
    pds_point_t        pt_a_reg, pt_a_next;
    pds_point_t        pt_b_reg, pt_b_next;
    logic [2:0][32:0]  dif_reg, dif_next;
    logic [65:0]       sum_reg, sum_next;
    logic [2:0]        k_reg, k_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [34:0]       cov_reg, cov_next;
    logic [16:0]       smp_f_reg, smp_f_next;
    logic [5:0][31:0]  smp_reg, smp_next;

    logic              sqrt_start;
    logic [LEN_W-1:0]  sqrt_root;
    logic              sqrt_done;
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [16:0]       div_quot;
    logic              div_done;

    pds_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({2'b00, sum_reg}),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    pds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (len_reg),
        .quot  (div_quot),
        .done  (div_done)
    );

    // scratch for the combinational block
    logic [7:0]         seg0, segs;
    logic [16:0]        frac0;
    logic [8:0]         n_m1;
    logic signed [35:0] d_ext, cov_s, len_s, rem_s, num_s;
    logic [32:0]        dsel;
    logic [65:0]        sq_prod;
    logic [50:0]        cov_prod;
    logic signed [32:0] a_c, b_c, dlt;
    logic signed [50:0] l_prod, l_q;
    logic signed [32:0] l_val;
    logic signed [32:0] dxa, dya, dza;

    always_comb
    begin
        state_next    = state_reg;
        cur_seg_next  = cur_seg_reg;
        cur_frac_next = cur_frac_reg;
        inside_next   = inside_reg;
        d_next        = d_reg;
        fwd_next      = fwd_reg;
        n_next        = n_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        pt_a_next     = pt_a_reg;
        pt_b_next     = pt_b_reg;
        dif_next      = dif_reg;
        sum_next      = sum_reg;
        k_next        = k_reg;
        len_next      = len_reg;
        cov_next      = cov_reg;
        smp_f_next    = smp_f_reg;
        smp_next      = smp_reg;
        rd_index      = pa_reg;
        sqrt_start    = 1'b0;
        div_start     = 1'b0;

        seg0  = cur_seg_reg;
        frac0 = cur_frac_reg;
        segs  = cur_seg_reg;
        n_m1  = n_reg - 9'd1;

        d_ext = {{4{d_reg[31]}}, d_reg};
        cov_s = {1'b0, cov_reg};
        len_s = {2'b00, len_reg};
        rem_s = len_s - cov_s;
        num_s = cov_s + d_ext;
        div_num = num_s;

        dsel     = dif_reg[k_reg[1:0]];
        sq_prod  = dsel * dsel;
        cov_prod = cur_frac_reg * len_reg;

        dxa = {rd_data.x[31], rd_data.x} - {pt_a_reg.x[31], pt_a_reg.x};
        dya = {rd_data.y[31], rd_data.y} - {pt_a_reg.y[31], pt_a_reg.y};
        dza = {rd_data.z[31], rd_data.z} - {pt_a_reg.z[31], pt_a_reg.z};

        unique case (k_reg)
            3'd0:
            begin
                a_c = {pt_a_reg.x[31], pt_a_reg.x};
                b_c = {pt_b_reg.x[31], pt_b_reg.x};
            end
            3'd1:
            begin
                a_c = {pt_a_reg.y[31], pt_a_reg.y};
                b_c = {pt_b_reg.y[31], pt_b_reg.y};
            end
            3'd2:
            begin
                a_c = {pt_a_reg.z[31], pt_a_reg.z};
                b_c = {pt_b_reg.z[31], pt_b_reg.z};
            end
            3'd3:
            begin
                a_c = {{17{pt_a_reg.ux[15]}}, pt_a_reg.ux};
                b_c = {{17{pt_b_reg.ux[15]}}, pt_b_reg.ux};
            end
            3'd4:
            begin
                a_c = {{17{pt_a_reg.uy[15]}}, pt_a_reg.uy};
                b_c = {{17{pt_b_reg.uy[15]}}, pt_b_reg.uy};
            end
            default:
            begin
                a_c = {{17{pt_a_reg.uz[15]}}, pt_a_reg.uz};
                b_c = {{17{pt_b_reg.uz[15]}}, pt_b_reg.uz};
            end
        endcase
        dlt    = b_c - a_c;
        l_prod = dlt * $signed({1'b0, smp_f_reg});
        // divide by 65536 rounding toward zero
        l_q    = (l_prod + (l_prod[50] ? 51'sd65535 : 51'sd0)) >>> 16;
        l_val  = a_c + l_q[32:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    n_next      = n_eff;
                    d_next      = req.distance;
                    fwd_next    = !req.distance[31];
                    inside_next = 1'b0;
                    if (req.opcode == OP_SET)
                    begin
                        if (req.distance[31] && (n_eff >= 9'd2))
                        begin
                            seg0  = 8'(n_eff - 9'd1);
                            frac0 = FRAC_ONE;
                        end
                        else
                        begin
                            seg0  = '0;
                            frac0 = '0;
                        end
                    end
                    if ((req.distance == 32'sd0) || (n_eff == 9'd0))
                    begin
                        cur_seg_next  = seg0;
                        cur_frac_next = frac0;
                        d_next        = '0;
                        state_next    = ST_SMP_RD_A;
                    end
                    else if (n_eff == 9'd1)
                    begin
                        cur_seg_next  = '0;
                        cur_frac_next = '0;
                        d_next        = '0;
                        state_next    = ST_SMP_RD_A;
                    end
                    else
                    begin
                        segs = ({1'b0, seg0} > (n_eff - 9'd1)) ? 8'(n_eff - 9'd1) : seg0;
                        cur_seg_next  = segs;
                        cur_frac_next = frac0;
                        pa_next       = segs;
                        if (!req.distance[31])
                        begin
                            if (({1'b0, segs} + 9'd1) >= n_eff)
                            begin
                                cur_frac_next = FRAC_ONE;
                                state_next    = ST_SMP_RD_A;
                            end
                            else
                            begin
                                pb_next    = segs + 8'd1;
                                state_next = ST_SEG_RD_A;
                            end
                        end
                        else
                        begin
                            pb_next = (({1'b0, segs} + 9'd1) < (n_eff - 9'd1)) ?
                                      (segs + 8'd1) : 8'(n_eff - 9'd1);
                            state_next = ST_SEG_RD_A;
                        end
                    end
                end
            end
            ST_SEG_RD_A:
            begin
                rd_index   = pa_reg;
                state_next = ST_SEG_RD_B;
            end
            ST_SEG_RD_B:
            begin
                rd_index   = pb_reg;
                pt_a_next  = rd_data;
                state_next = ST_SEG_DIFF;
            end
            ST_SEG_DIFF:
            begin
                dif_next[0] = dxa[32] ? 33'(-dxa) : dxa;
                dif_next[1] = dya[32] ? 33'(-dya) : dya;
                dif_next[2] = dza[32] ? 33'(-dza) : dza;
                sum_next    = '0;
                k_next      = '0;
                state_next  = ST_SEG_SQ;
            end
            ST_SEG_SQ:
            begin
                sum_next = sum_reg + sq_prod;
                k_next   = k_reg + 3'd1;
                if (k_reg == 3'd2)
                begin
                    state_next = ST_SEG_SQRT_GO;
                end
            end
            ST_SEG_SQRT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = ST_SEG_SQRT;
            end
            ST_SEG_SQRT:
            begin
                if (sqrt_done)
                begin
                    len_next   = sqrt_root;
                    state_next = ST_SEG_COV;
                end
            end
            ST_SEG_COV:
            begin
                cov_next   = cov_prod[50:16];
                state_next = ST_SEG_STEP;
            end
            ST_SEG_STEP:
            begin
                if (fwd_reg)
                begin
                    if (d_ext >= rem_s)
                    begin
                        d_next        = 32'(d_ext - rem_s);
                        cur_seg_next  = pb_reg;
                        cur_frac_next = '0;
                        if (({1'b0, pb_reg} + 9'd1) < n_reg)
                        begin
                            pa_next    = pb_reg;
                            pb_next    = pb_reg + 8'd1;
                            state_next = ST_SEG_RD_A;
                        end
                        else
                        begin
                            cur_frac_next = FRAC_ONE;
                            state_next    = ST_SMP_RD_A;
                        end
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_SEG_DIV;
                    end
                end
                else
                begin
                    if (d_ext <= -cov_s)
                    begin
                        d_next = 32'(d_ext + cov_s);
                        if (cur_seg_reg == 8'd0)
                        begin
                            cur_frac_next = '0;
                            state_next    = ST_SMP_RD_A;
                        end
                        else
                        begin
                            cur_seg_next  = cur_seg_reg - 8'd1;
                            cur_frac_next = FRAC_ONE;
                            pa_next       = cur_seg_reg - 8'd1;
                            pb_next       = cur_seg_reg;
                            state_next    = ST_SEG_RD_A;
                        end
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_SEG_DIV;
                    end
                end
            end
            ST_SEG_DIV:
            begin
                if (div_done)
                begin
                    cur_frac_next = div_quot;
                    inside_next   = 1'b1;
                    state_next    = ST_SMP_RD_A;
                end
            end
            ST_SMP_RD_A:
            begin
                if (n_reg == 9'd0)
                begin
                    smp_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (({1'b0, cur_seg_reg} + 9'd1) >= n_reg)
                    begin
                        rd_index   = 8'(n_m1);
                        pb_next    = 8'(n_m1);
                        smp_f_next = '0;
                    end
                    else
                    begin
                        rd_index   = cur_seg_reg;
                        pb_next    = cur_seg_reg + 8'd1;
                        smp_f_next = cur_frac_reg;
                    end
                    state_next = ST_SMP_RD_B;
                end
            end
            ST_SMP_RD_B:
            begin
                rd_index   = pb_reg;
                pt_a_next  = rd_data;
                state_next = ST_SMP_LATCH;
            end
            ST_SMP_LATCH:
            begin
                pt_b_next  = rd_data;
                k_next     = '0;
                state_next = ST_SMP_LERP;
            end
            ST_SMP_LERP:
            begin
                smp_next[k_reg] = l_val[31:0];
                k_next          = k_reg + 3'd1;
                if (k_reg == 3'd5)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cur_seg_reg  <= '0;
            cur_frac_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_seg_reg  <= cur_seg_next;
            cur_frac_reg <= cur_frac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg <= inside_next;
        d_reg      <= d_next;
        fwd_reg    <= fwd_next;
        n_reg      <= n_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        pt_a_reg   <= pt_a_next;
        pt_b_reg   <= pt_b_next;
        dif_reg    <= dif_next;
        sum_reg    <= sum_next;
        k_reg      <= k_next;
        len_reg    <= len_next;
        cov_reg    <= cov_next;
        smp_f_reg  <= smp_f_next;
        smp_reg    <= smp_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res.inside_res       = inside_reg;
        res.leftover         = d_reg;
        res.segment_index    = cur_seg_reg;
        res.segment_fraction = cur_frac_reg;
        res.sample_x         = smp_reg[0];
        res.sample_y         = smp_reg[1];
        res.sample_z         = smp_reg[2];
        res.sample_up_x      = smp_reg[3][15:0];
        res.sample_up_y      = smp_reg[4][15:0];
        res.sample_up_z      = smp_reg[5][15:0];
    end

endmodule

`default_nettype wire

// ===== rtl/core/polyline_distance_sampler.sv =====
// Polyline distance sampler, top level.
// Request channel (req_valid, req_stall, req) carries point loads and cursor
// operations; response channel (rsp_valid, rsp_stall, rsp) returns one item per
// set or advance request. Loads and opcode 3 return nothing.
// A load writes the point ram directly in the cycle it is taken.
// A cursor request walks segments one at a time through the point ram's single
// read port, a 33x33 squarer and a 34-step square root unit, then runs the
// fraction divide when the cursor stops inside a segment, then reads both end
// points and interpolates six components one per cycle. A walk that stops at
// once goes straight to the sampling steps.
// req_stall is high while a cursor request is in flight. A finished response
// sits in the output register while the next request is taken; while
// rsp_stall holds it, a second finished response waits inside the walker.
// Reset clears the cursor to segment 0 fraction 0 and point_count to 0; the
// point ram is not cleared and must be loaded before use.
// depends on pds_pkg, pds_ram, pds_walker
`default_nettype none

module polyline_distance_sampler #(
    parameter int POINT_DEPTH = pds_pkg::POINT_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire pds_pkg::pds_req_t    req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output pds_pkg::pds_rsp_t         rsp,
    input  wire logic                 point_count_we,
    input  wire logic [8:0]           point_count_data
);
    import pds_pkg::*;

    localparam int AW  = $clog2(POINT_DEPTH);
    localparam int CAP = (POINT_DEPTH < COUNT_CAP) ? POINT_DEPTH : COUNT_CAP;

    logic [8:0]  point_count_reg;
    logic [8:0]  n_eff;
    logic        req_fire;
    logic        load_we;
    logic        walk_go;
    logic        walk_busy;
    logic [7:0]  rd_index;
    logic [POINT_W-1:0] rd_raw;
    pds_point_t  rd_point;
    pds_point_t  wr_point;
    pds_rsp_t    walk_res;
    logic        walk_valid;
    logic        walk_take;
    pds_rsp_t    rsp_reg;
    logic        rsp_valid_reg;

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = walk_busy;
    assign load_we   = req_fire && (req.opcode == OP_LOAD) &&
                       (32'(req.point_index) < POINT_DEPTH);
    assign walk_go   = req_fire && ((req.opcode == OP_SET) || (req.opcode == OP_ADVANCE));
    assign n_eff     = (32'(point_count_reg) > CAP) ? 9'(CAP) : point_count_reg;

    always_comb
    begin
        wr_point.x  = req.pos_x;
        wr_point.y  = req.pos_y;
        wr_point.z  = req.pos_z;
        wr_point.ux = req.up_x;
        wr_point.uy = req.up_y;
        wr_point.uz = req.up_z;
        rd_point    = pds_point_t'(rd_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (point_count_we)
        begin
            point_count_reg <= point_count_data;
        end
    end

    pds_ram #(
        .WIDTH (POINT_W),
        .DEPTH (POINT_DEPTH)
    ) u_point_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(req.point_index)),
        .wdata (wr_point),
        .raddr (AW'(rd_index)),
        .rdata (rd_raw)
    );

    pds_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (walk_go),
        .req       (req),
        .n_eff     (n_eff),
        .busy      (walk_busy),
        .rd_index  (rd_index),
        .rd_data   (rd_point),
        .res       (walk_res),
        .res_valid (walk_valid),
        .res_take  (walk_take)
    );

    // output register, filled when empty and refilled as soon as the consumer takes the current one
    assign walk_take = walk_valid && (!rsp_valid_reg || !rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (walk_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (walk_take)
        begin
            rsp_reg <= walk_res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.segment_fraction <= FRAC_ONE))
        else $error("cursor fraction above one");

    a_inside_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.inside_res) |-> (rsp.segment_fraction != FRAC_ONE))
        else $error("inside cursor at segment end");

    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req.opcode == OP_LOAD)) |=> !req_stall)
        else $error("load request left the walker busy");

    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && ((req.opcode == OP_SET) || (req.opcode == OP_ADVANCE)))
        |=> req_stall)
        else $error("cursor request did not start the walker");
`endif

endmodule

`default_nettype wire
